// ----- design/askf_pkg.sv -----
// shared types, constants and micro-program of the altitude/speed kalman filter
package askf_pkg;

  // number format: signed fixed point, data width and fraction bits
  localparam int DW    = 32;
  localparam int FB    = 16;
  localparam int NUM_W = DW + FB;

  typedef logic signed [DW-1:0] fix_t;

  localparam fix_t VMAX    = {1'b0, {(DW-1){1'b1}}};
  localparam fix_t VMIN    = {1'b1, {(DW-1){1'b0}}};
  localparam fix_t ONE_FIX = fix_t'(64'd1 << FB);

  // register field widths and reset values
  localparam int TS_W = 17;
  localparam int NZ_W = 31;
  localparam logic [TS_W-1:0] TS_RESET = 17'd6554;
  localparam logic [NZ_W-1:0] PN_RESET = 31'd655;
  localparam logic [NZ_W-1:0] MN_RESET = 31'd65536;
  localparam logic [NZ_W-1:0] IV_RESET = 31'd6553600;

  // configuration register indexes
  localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
  localparam logic [1:0] CFG_PROC_NOISE  = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;
  localparam logic [1:0] CFG_INIT_VAR    = 2'd3;

  // commands
  localparam logic [1:0] CMD_PREDICT = 2'd0;
  localparam logic [1:0] CMD_UPDATE  = 2'd1;
  localparam logic [1:0] CMD_SET     = 2'd2;

  // shared unit operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // operand and destination selects
  localparam logic [3:0] RG_ALT = 4'd0;
  localparam logic [3:0] RG_SPD = 4'd1;
  localparam logic [3:0] RG_P0  = 4'd2;
  localparam logic [3:0] RG_P1  = 4'd3;
  localparam logic [3:0] RG_P2  = 4'd4;
  localparam logic [3:0] RG_P3  = 4'd5;
  localparam logic [3:0] RG_T0  = 4'd6;
  localparam logic [3:0] RG_T1  = 4'd7;
  localparam logic [3:0] RG_T2  = 4'd8;
  localparam logic [3:0] RG_T3  = 4'd9;
  localparam logic [3:0] RG_DT  = 4'd10;
  localparam logic [3:0] RG_Q   = 4'd11;
  localparam logic [3:0] RG_R   = 4'd12;
  localparam logic [3:0] RG_ONE = 4'd13;
  localparam logic [3:0] RG_Z   = 4'd14;

  // program entry points
  localparam logic [4:0] PC_PREDICT = 5'd0;
  localparam logic [4:0] PC_UPDATE  = 5'd16;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [31:0] measured_altitude;
    logic signed [31:0] start_altitude;
    logic signed [31:0] start_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] altitude_estimate;
    logic signed [31:0] speed_estimate;
  } out_item_t;

  // one micro-operation: dst = op(sa, sb), optional stop on non-positive result
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] dst;
    logic [3:0] sa;
    logic [3:0] sb;
    logic       chk;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    fix_t       a;
    fix_t       b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    fix_t y;
  } alu_rsp_t;

  // predict: P = F*P*F^T + Q, alt += dt*spd; update: gain, state and covariance correction
  function automatic uop_t prog(input logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_MUL, RG_T0,  RG_DT,  RG_P2,  1'b0, 1'b0};
      5'd1:  u = '{OP_ADD, RG_T1,  RG_P0,  RG_T0,  1'b0, 1'b0};
      5'd2:  u = '{OP_MUL, RG_T0,  RG_DT,  RG_P3,  1'b0, 1'b0};
      5'd3:  u = '{OP_ADD, RG_P1,  RG_P1,  RG_T0,  1'b0, 1'b0};
      5'd4:  u = '{OP_ADD, RG_P2,  RG_P2,  RG_T0,  1'b0, 1'b0};
      5'd5:  u = '{OP_MUL, RG_T0,  RG_DT,  RG_SPD, 1'b0, 1'b0};
      5'd6:  u = '{OP_ADD, RG_ALT, RG_ALT, RG_T0,  1'b0, 1'b0};
      5'd7:  u = '{OP_MUL, RG_T0,  RG_DT,  RG_P1,  1'b0, 1'b0};
      5'd8:  u = '{OP_ADD, RG_T0,  RG_T1,  RG_T0,  1'b0, 1'b0};
      5'd9:  u = '{OP_ADD, RG_P0,  RG_T0,  RG_Q,   1'b0, 1'b0};
      5'd10: u = '{OP_ADD, RG_P3,  RG_P3,  RG_Q,   1'b0, 1'b1};
      5'd16: u = '{OP_ADD, RG_T0,  RG_P0,  RG_R,   1'b1, 1'b0};
      5'd17: u = '{OP_SUB, RG_T1,  RG_Z,   RG_ALT, 1'b0, 1'b0};
      5'd18: u = '{OP_DIV, RG_T2,  RG_P0,  RG_T0,  1'b0, 1'b0};
      5'd19: u = '{OP_DIV, RG_T3,  RG_P2,  RG_T0,  1'b0, 1'b0};
      5'd20: u = '{OP_MUL, RG_T0,  RG_T2,  RG_T1,  1'b0, 1'b0};
      5'd21: u = '{OP_ADD, RG_ALT, RG_ALT, RG_T0,  1'b0, 1'b0};
      5'd22: u = '{OP_MUL, RG_T0,  RG_T3,  RG_T1,  1'b0, 1'b0};
      5'd23: u = '{OP_ADD, RG_SPD, RG_SPD, RG_T0,  1'b0, 1'b0};
      5'd24: u = '{OP_SUB, RG_T2,  RG_ONE, RG_T2,  1'b0, 1'b0};
      5'd25: u = '{OP_MUL, RG_T0,  RG_T3,  RG_P0,  1'b0, 1'b0};
      5'd26: u = '{OP_SUB, RG_P2,  RG_P2,  RG_T0,  1'b0, 1'b0};
      5'd27: u = '{OP_MUL, RG_T0,  RG_T3,  RG_P1,  1'b0, 1'b0};
      5'd28: u = '{OP_SUB, RG_P3,  RG_P3,  RG_T0,  1'b0, 1'b0};
      5'd29: u = '{OP_MUL, RG_P0,  RG_T2,  RG_P0,  1'b0, 1'b0};
      5'd30: u = '{OP_MUL, RG_P1,  RG_T2,  RG_P1,  1'b0, 1'b1};
      default: u = '{OP_ADD, RG_T0, RG_T0, RG_T0, 1'b0, 1'b1};
    endcase
    return u;
  endfunction

endpackage

// ----- design/askf_alu.sv -----
// shared saturating fixed-point unit: add, subtract, multiply, bit-serial divide
module askf_alu import askf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam logic [1:0] AS_IDLE = 2'd0;
  localparam logic [1:0] AS_MUL  = 2'd1;
  localparam logic [1:0] AS_DIV  = 2'd2;
  localparam logic [1:0] AS_RND  = 2'd3;

  localparam int CNT_W = $clog2(NUM_W);
  localparam int MAG_W = 2 * DW + 1;
  localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (FB - 1);

  logic [1:0]        state_q, state_d;
  logic              neg_q;
  logic [2*DW-1:0]   prod_q;
  logic [NUM_W-1:0]  num_q;
  logic [DW:0]       rem_q;
  logic [DW-1:0]     den_q;
  logic [CNT_W-1:0]  cnt_q;
  fix_t              y_q;
  logic              done_q;

  function automatic logic [DW-1:0] mag(input fix_t v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // signed result from sign and magnitude, saturated
  function automatic fix_t sat_mag(input logic neg, input logic [MAG_W-1:0] m);
    logic big;
    big = m > MAG_W'(VMAX);
    if (neg) begin
      return big ? VMIN : fix_t'(-m[DW-1:0]);
    end
    return big ? VMAX : fix_t'(m[DW-1:0]);
  endfunction

  // add and subtract with saturation
  logic [DW:0] add_ext;
  fix_t        add_y;
  always_comb begin
    if (req_i.op == OP_SUB) begin
      add_ext = {req_i.a[DW-1], req_i.a} - {req_i.b[DW-1], req_i.b};
    end else begin
      add_ext = {req_i.a[DW-1], req_i.a} + {req_i.b[DW-1], req_i.b};
    end
    if (add_ext[DW] != add_ext[DW-1]) begin
      add_y = add_ext[DW] ? VMIN : VMAX;
    end else begin
      add_y = fix_t'(add_ext[DW-1:0]);
    end
  end

  // multiply rounding: add half, drop fraction bits
  logic [MAG_W-1:0] mul_rnd;
  assign mul_rnd = ({1'b0, prod_q} + HALF) >> FB;

  // one restoring division step
  logic [DW:0] rem_sh, rem_step;
  logic        q_bit;
  assign rem_sh   = {rem_q[DW-1:0], num_q[NUM_W-1]};
  assign q_bit    = rem_sh >= {1'b0, den_q};
  assign rem_step = q_bit ? rem_sh - {1'b0, den_q} : rem_sh;

  // final quotient rounding, ties away from zero
  logic             rnd_up;
  logic [NUM_W:0]   quo_rnd;
  assign rnd_up  = rem_q >= ({1'b0, den_q} - rem_q);
  assign quo_rnd = {1'b0, num_q} + (NUM_W+1)'(rnd_up);

  // sequencing of the unit
  always_comb begin
    state_d = state_q;
    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_MUL:  state_d = AS_MUL;
            OP_DIV:  state_d = AS_DIV;
            default: state_d = AS_IDLE;
          endcase
        end
      end
      AS_MUL:  state_d = AS_IDLE;
      AS_DIV:  state_d = (cnt_q == '0) ? AS_RND : AS_DIV;
      AS_RND:  state_d = AS_IDLE;
      default: state_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        AS_IDLE: done_q <= req_i.start && (req_i.op == OP_ADD || req_i.op == OP_SUB);
        AS_MUL:  done_q <= 1'b1;
        AS_RND:  done_q <= 1'b1;
        default: done_q <= 1'b0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          neg_q  <= req_i.a[DW-1] ^ (req_i.op == OP_MUL && req_i.b[DW-1]);
          prod_q <= mag(req_i.a) * mag(req_i.b);
          num_q  <= {mag(req_i.a), {FB{1'b0}}};
          rem_q  <= '0;
          den_q  <= req_i.b[DW-1:0];
          cnt_q  <= CNT_W'(NUM_W - 1);
          y_q    <= add_y;
        end
      end
      AS_MUL: y_q <= sat_mag(neg_q, mul_rnd);
      AS_DIV: begin
        rem_q <= rem_step;
        num_q <= {num_q[NUM_W-2:0], q_bit};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      AS_RND:  y_q <= sat_mag(neg_q, MAG_W'(quo_rnd));
      default: y_q <= y_q;
    endcase
  end

  assign rsp_o = '{done: done_q, y: y_q};

endmodule

// ----- design/altitude_speed_kalman_filter_core.sv -----
// top level of the two-state altitude and vertical speed kalman filter
//
// Input channel (in_valid_i / in_stall_o / in_item_i) carries one command per
// transaction: predict, update with a measured altitude, or set state. Output
// channel (out_valid_o / out_stall_i / out_item_o) returns one transaction per
// command with the altitude and speed estimates held after it.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken; write them
// only while the block is idle.
// All arithmetic runs through one shared saturating unit under a micro-program:
// add, subtract, multiply and divide, the divide going through issue, one
// quotient bit per cycle over 48 bits, rounding and hand-back. An update runs
// two divides for the gain and stops early when the innovation variance is not
// positive; set state and the unused command use no arithmetic.
// One command is in flight at a time; in_stall_o is high from the cycle after
// acceptance until the result is loaded into the output register, which lets
// the next command be accepted while a result waits. If the receiver stalls, a
// finished result holds until the output register frees up. Reset loads the
// register defaults, zero state and the diagonal initial covariance.
module altitude_speed_kalman_filter_core import askf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]      state_q;
  logic [4:0]      pc_q;
  logic [TS_W-1:0] dt_q;
  logic [NZ_W-1:0] pn_q, mn_q, iv_q;
  fix_t            alt_q, spd_q, p0_q, p1_q, p2_q, p3_q;
  fix_t            t0_q, t1_q, t2_q, t3_q, z_q;
  logic            out_valid_q;
  out_item_t       out_q;

  uop_t     uop;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  fix_t     r_val;
  logic     in_acc, out_free, stop;

  assign uop      = prog(pc_q);
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign r_val    = (mn_q == '0) ? fix_t'(1) : fix_t'(mn_q);
  assign stop     = uop.last || (uop.chk && (alu_rsp.y[DW-1] || alu_rsp.y == '0));

  // operand select
  function automatic fix_t rd(input logic [3:0] idx);
    case (idx)
      RG_ALT:  return alt_q;
      RG_SPD:  return spd_q;
      RG_P0:   return p0_q;
      RG_P1:   return p1_q;
      RG_P2:   return p2_q;
      RG_P3:   return p3_q;
      RG_T0:   return t0_q;
      RG_T1:   return t1_q;
      RG_T2:   return t2_q;
      RG_T3:   return t3_q;
      RG_DT:   return fix_t'(dt_q);
      RG_Q:    return fix_t'(pn_q);
      RG_R:    return r_val;
      RG_ONE:  return ONE_FIX;
      RG_Z:    return z_q;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    alu_req.start = (state_q == ST_ISSUE);
    alu_req.op    = uop.op;
    alu_req.a     = rd(uop.sa);
    alu_req.b     = rd(uop.sb);
  end

  askf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= TS_RESET;
      pn_q <= PN_RESET;
      mn_q <= MN_RESET;
      iv_q <= IV_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TIME_STEP:  dt_q <= cfg_data_i[TS_W-1:0];
        CFG_PROC_NOISE: pn_q <= cfg_data_i[NZ_W-1:0];
        CFG_MEAS_NOISE: mn_q <= cfg_data_i[NZ_W-1:0];
        CFG_INIT_VAR:   iv_q <= cfg_data_i[NZ_W-1:0];
        default:        dt_q <= dt_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= PC_PREDICT;
      alt_q   <= '0;
      spd_q   <= '0;
      p0_q    <= fix_t'(IV_RESET);
      p1_q    <= '0;
      p2_q    <= '0;
      p3_q    <= fix_t'(IV_RESET);
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_item_i.cmd)
              CMD_PREDICT: begin
                pc_q    <= PC_PREDICT;
                state_q <= ST_ISSUE;
              end
              CMD_UPDATE: begin
                pc_q    <= PC_UPDATE;
                state_q <= ST_ISSUE;
              end
              CMD_SET: begin
                alt_q   <= in_item_i.start_altitude;
                spd_q   <= in_item_i.start_speed;
                p0_q    <= fix_t'(iv_q);
                p1_q    <= '0;
                p2_q    <= '0;
                p3_q    <= fix_t'(iv_q);
                state_q <= ST_FIN;
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end
        ST_ISSUE: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (alu_rsp.done) begin
            case (uop.dst)
              RG_ALT:  alt_q <= alu_rsp.y;
              RG_SPD:  spd_q <= alu_rsp.y;
              RG_P0:   p0_q  <= alu_rsp.y;
              RG_P1:   p1_q  <= alu_rsp.y;
              RG_P2:   p2_q  <= alu_rsp.y;
              RG_P3:   p3_q  <= alu_rsp.y;
              default: alt_q <= alt_q;
            endcase
            pc_q    <= pc_q + 5'd1;
            state_q <= stop ? ST_FIN : ST_ISSUE;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // temporaries and captured measurement
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      z_q <= in_item_i.measured_altitude;
    end
    if (state_q == ST_WAIT && alu_rsp.done) begin
      case (uop.dst)
        RG_T0:   t0_q <= alu_rsp.y;
        RG_T1:   t1_q <= alu_rsp.y;
        RG_T2:   t2_q <= alu_rsp.y;
        RG_T3:   t3_q <= alu_rsp.y;
        default: t0_q <= t0_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_q <= '{altitude_estimate: alt_q, speed_estimate: spd_q};
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // the shared unit only answers a request issued by the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == ST_WAIT)
    else $error("shared unit finished without a pending request");

  // an accepted command always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted transaction was dropped");

  // a finished result never overwrites one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && state_q == ST_FIN |=> state_q == ST_FIN)
    else $error("result loaded over a stalled transaction");

endmodule

// ----- tb/tb_altitude_speed_kalman_filter_core.sv -----
// testbench for the altitude/speed kalman filter core: directed table, random tracks, predictor
module tb_altitude_speed_kalman_filter_core import askf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RAND_ITEMS   = 1575;
  localparam int QUIET_FROM   = RAND_ITEMS - 200;
  localparam int TAIL_CYCLES  = 200;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint unsigned MAG_MAX = (64'd1 << (DW - 1)) - 1;

  typedef enum logic [1:0] {ROW_WRITE, ROW_CMD, ROW_KNOWN} row_kind_e;

  // one line of the directed table
  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] idx;
    logic [31:0] data;
    in_item_t   item;
    out_item_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic        quiet = 1'b0;
  int          stall_burst = 0;
  int          cycle_cnt = 0;
  int          error_cnt = 0;

  // predictor copy of registers and filter state
  logic [TS_W-1:0] cfg_dt = TS_RESET;
  logic [NZ_W-1:0] cfg_pn = PN_RESET;
  logic [NZ_W-1:0] cfg_mn = MN_RESET;
  logic [NZ_W-1:0] cfg_iv = IV_RESET;
  fix_t est_alt = '0;
  fix_t est_spd = '0;
  fix_t cov [4] = '{fix_t'({1'b0, IV_RESET}), '0, '0, fix_t'({1'b0, IV_RESET})};

  out_item_t estimate_q [$];

  always #1 clk = ~clk;

  altitude_speed_kalman_filter_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // saturating fixed point arithmetic
  function automatic fix_t clip(longint t);
    if (t > longint'(VMAX)) return VMAX;
    if (t < longint'(VMIN)) return VMIN;
    return fix_t'(t);
  endfunction

  function automatic fix_t fx_add(fix_t a, fix_t b);
    return clip(longint'(a) + longint'(b));
  endfunction

  function automatic fix_t fx_sub(fix_t a, fix_t b);
    return clip(longint'(a) - longint'(b));
  endfunction

  function automatic longint unsigned mag_of(fix_t a);
    longint v;
    v = a;
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic fix_t from_magnitude(bit neg, longint unsigned m);
    if (m > MAG_MAX) return neg ? VMIN : VMAX;
    return neg ? fix_t'(-longint'(m)) : fix_t'(m);
  endfunction

  // product rounded to nearest, ties away from zero
  function automatic fix_t fx_mul(fix_t a, fix_t b);
    longint unsigned p;
    p = mag_of(a) * mag_of(b);
    p = (p + (64'd1 << (FB - 1))) >> FB;
    return from_magnitude((a < 0) != (b < 0), p);
  endfunction

  // quotient (a << FB) / b for b > 0, rounded to nearest
  function automatic fix_t fx_div(fix_t a, fix_t b);
    longint unsigned num, den, quo, rem;
    num = mag_of(a) << FB;
    den = mag_of(b);
    quo = num / den;
    rem = num % den;
    if (rem >= den - rem) quo = quo + 1;
    return from_magnitude(a < 0, quo);
  endfunction

  // advance the predicted filter by one command, return the estimates
  function automatic out_item_t filter_step(in_item_t it);
    fix_t dt, q, r, iv, s, y, k0, k1, ik, fp00, fp01, dtp3, n0, n1, n2, n3;
    out_item_t o;
    dt = fix_t'({15'd0, cfg_dt});
    q  = fix_t'({1'b0, cfg_pn});
    r  = (cfg_mn == '0) ? fix_t'(1) : fix_t'({1'b0, cfg_mn});
    iv = fix_t'({1'b0, cfg_iv});
    case (it.cmd)
      CMD_PREDICT: begin
        dtp3 = fx_mul(dt, cov[3]);
        fp00 = fx_add(cov[0], fx_mul(dt, cov[2]));
        fp01 = fx_add(cov[1], dtp3);
        est_alt = fx_add(est_alt, fx_mul(dt, est_spd));
        cov[0] = fx_add(fx_add(fp00, fx_mul(dt, fp01)), q);
        cov[1] = fp01;
        cov[2] = fx_add(cov[2], dtp3);
        cov[3] = fx_add(cov[3], q);
      end
      CMD_UPDATE: begin
        s = fx_add(cov[0], r);
        // non-positive innovation leaves everything as it is
        if (s > 0) begin
          y  = fx_sub(it.measured_altitude, est_alt);
          k0 = fx_div(cov[0], s);
          k1 = fx_div(cov[2], s);
          est_alt = fx_add(est_alt, fx_mul(k0, y));
          est_spd = fx_add(est_spd, fx_mul(k1, y));
          ik = fx_sub(ONE_FIX, k0);
          n0 = fx_mul(ik, cov[0]);
          n1 = fx_mul(ik, cov[1]);
          n2 = fx_sub(cov[2], fx_mul(k1, cov[0]));
          n3 = fx_sub(cov[3], fx_mul(k1, cov[1]));
          cov = '{n0, n1, n2, n3};
        end
      end
      CMD_SET: begin
        est_alt = it.start_altitude;
        est_spd = it.start_speed;
        cov = '{iv, '0, '0, iv};
      end
      default: ;
    endcase
    o.altitude_estimate = est_alt;
    o.speed_estimate    = est_spd;
    return o;
  endfunction

  function automatic dir_row_t write_row(logic [1:0] idx, logic [31:0] data);
    dir_row_t d;
    d = '0;
    d.kind = ROW_WRITE;
    d.idx  = idx;
    d.data = data;
    return d;
  endfunction

  function automatic dir_row_t cmd_row(logic [1:0] cmd, fix_t z, fix_t a, fix_t s);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CMD;
    d.item = '{cmd, z, a, s};
    return d;
  endfunction

  function automatic dir_row_t known_row(logic [1:0] cmd, fix_t a, fix_t s, fix_t ea, fix_t es);
    dir_row_t d;
    d = '0;
    d.kind = ROW_KNOWN;
    d.item = '{cmd, a, a, s};
    d.want = '{ea, es};
    return d;
  endfunction

  // random values: mostly a realistic span around zero, sometimes the extremes
  function automatic fix_t small_value();
    int v;
    v = $urandom_range(0, 16777215);
    return fix_t'(v - 8388608);
  endfunction

  function automatic fix_t wide_value();
    case ($urandom_range(0, 9))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3, 4: return fix_t'($urandom);
      default: return small_value();
    endcase
  endfunction

  // next command of a track: predicts and updates in random order with the odd restart or unused code
  function automatic in_item_t random_cmd();
    in_item_t it;
    int pick;
    it.cmd = CMD_PREDICT;
    it.measured_altitude = $urandom;
    it.start_altitude = $urandom;
    it.start_speed = $urandom;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      it.cmd = CMD_PREDICT;
    end else if (pick < 16) begin
      it.cmd = CMD_UPDATE;
      it.measured_altitude = (pick < 14) ? fx_add(est_alt, small_value()) : wide_value();
    end else if (pick < 19) begin
      it.cmd = CMD_SET;
      it.start_altitude = wide_value();
      it.start_speed = wide_value();
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  function automatic logic [31:0] random_reg(logic [1:0] idx);
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 2) return $urandom;
    case (idx)
      CFG_TIME_STEP:  return (pick == 0) ? 32'd0 : (pick == 1) ? 32'h0001_FFFF :
                             $urandom_range(600, 70000);
      CFG_PROC_NOISE: return (pick == 0) ? 32'd0 : (pick == 1) ? 32'h7FFF_FFFF :
                             $urandom_range(0, 70000);
      CFG_MEAS_NOISE: return (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 :
                             $urandom_range(1000, 2000000);
      default:        return (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                             $urandom_range(65536, 100000000);
    endcase
  endfunction

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  // one configuration transaction, mirrored into the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TIME_STEP:  cfg_dt = data[TS_W-1:0];
      CFG_PROC_NOISE: cfg_pn = data[NZ_W-1:0];
      CFG_MEAS_NOISE: cfg_mn = data[NZ_W-1:0];
      CFG_INIT_VAR:   cfg_iv = data[NZ_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one command transaction; the expected estimates are queued on acceptance
  task automatic send_cmd(input in_item_t it, input bit typed, input out_item_t typed_want);
    out_item_t predicted;
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = filter_step(it);
    estimate_q.push_back(typed ? typed_want : predicted);
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every queued result has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (estimate_q.size() != 0) @(posedge clk);
  endtask

  // random receiver stall bursts
  always @(posedge clk) begin
    if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_burst <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (estimate_q.size() == 0) begin
        note_error($sformatf("unexpected result alt=%0d spd=%0d",
                             out_item.altitude_estimate, out_item.speed_estimate));
      end else begin
        want = estimate_q.pop_front();
        if (out_item.altitude_estimate !== want.altitude_estimate)
          note_error($sformatf("altitude expected %0d got %0d",
                               want.altitude_estimate, out_item.altitude_estimate));
        if (out_item.speed_estimate !== want.speed_estimate)
          note_error($sformatf("speed expected %0d got %0d",
                               want.speed_estimate, out_item.speed_estimate));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               estimate_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t rows [$];
    dir_row_t d;
    in_item_t it;
    int done_items;
    int phase_len;

    // after reset, extremes, unused code
    rows.push_back(known_row(CMD_PREDICT, VMAX, VMIN, '0, '0));
    rows.push_back(cmd_row(CMD_UPDATE, VMAX, VMIN, VMAX));
    rows.push_back(cmd_row(CMD_UPDATE, VMIN, VMAX, VMIN));
    rows.push_back(cmd_row(CMD_PREDICT, '0, '0, '0));
    rows.push_back(known_row(CMD_SET, VMAX, VMAX, VMAX, VMAX));
    rows.push_back(cmd_row(CMD_PREDICT, '1, '1, '1));
    rows.push_back(known_row(CMD_SET, VMIN, VMIN, VMIN, VMIN));
    rows.push_back(known_row(CMD_UNUSED, '1, '1, VMIN, VMIN));
    rows.push_back(cmd_row(CMD_PREDICT, '0, '0, '0));
    rows.push_back(cmd_row(CMD_UPDATE, '0, '0, '0));
    // zero measurement noise and zero time step
    rows.push_back(write_row(CFG_MEAS_NOISE, 32'd0));
    rows.push_back(write_row(CFG_TIME_STEP, 32'd0));
    rows.push_back(known_row(CMD_SET, 32'sh03E8_0000, -32'sd5, 32'sh03E8_0000, -32'sd5));
    rows.push_back(cmd_row(CMD_UPDATE, 32'sh0C00_0000, '0, '0));
    rows.push_back(cmd_row(CMD_PREDICT, '0, '0, '0));
    // every register at its top value, data bits above the register width set for time step and measurement noise
    rows.push_back(write_row(CFG_TIME_STEP, 32'hFFFF_FFFF));
    rows.push_back(write_row(CFG_PROC_NOISE, 32'h7FFF_FFFF));
    rows.push_back(write_row(CFG_MEAS_NOISE, 32'hFFFF_FFFF));
    rows.push_back(write_row(CFG_INIT_VAR, 32'h7FFF_FFFF));
    rows.push_back(known_row(CMD_SET, '0, VMAX, '0, VMAX));
    rows.push_back(cmd_row(CMD_PREDICT, '0, '0, '0));
    rows.push_back(cmd_row(CMD_UPDATE, VMIN, '0, '0));
    rows.push_back(cmd_row(CMD_UPDATE, VMAX, '0, '0));
    // saturated covariance drives p00 negative, then an update must leave the state alone
    rows.push_back(write_row(CFG_TIME_STEP, 32'h0001_FFFF));
    rows.push_back(write_row(CFG_PROC_NOISE, 32'd0));
    rows.push_back(write_row(CFG_MEAS_NOISE, 32'd1));
    rows.push_back(write_row(CFG_INIT_VAR, 32'd644245094));
    rows.push_back(known_row(CMD_SET, '0, '0, '0, '0));
    rows.push_back(cmd_row(CMD_PREDICT, '0, '0, '0));
    rows.push_back(cmd_row(CMD_UPDATE, 32'sh000F_4240, '0, '0));
    rows.push_back(cmd_row(CMD_PREDICT, '0, '0, '0));
    rows.push_back(cmd_row(CMD_UPDATE, 32'sh1000_0000, '0, '0));
    // zero initial variance, defaults back
    rows.push_back(write_row(CFG_INIT_VAR, 32'd0));
    rows.push_back(write_row(CFG_TIME_STEP, 32'(TS_RESET)));
    rows.push_back(write_row(CFG_PROC_NOISE, 32'(PN_RESET)));
    rows.push_back(write_row(CFG_MEAS_NOISE, 32'(MN_RESET)));
    rows.push_back(known_row(CMD_SET, 32'sd5, -32'sd5, 32'sd5, -32'sd5));
    rows.push_back(cmd_row(CMD_UPDATE, 32'sh0001_0000, '0, '0));
    rows.push_back(cmd_row(CMD_PREDICT, '0, '0, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      d = rows[i];
      if (d.kind == ROW_WRITE) begin
        wait_results_done();
        write_reg(d.idx, d.data);
      end else begin
        send_cmd(d.item, d.kind == ROW_KNOWN, d.want);
      end
    end

    // random phases: new register setting, then a track opened by a set
    done_items = 0;
    while (done_items < RAND_ITEMS) begin
      wait_results_done();
      write_reg(CFG_TIME_STEP, random_reg(CFG_TIME_STEP));
      write_reg(CFG_PROC_NOISE, random_reg(CFG_PROC_NOISE));
      write_reg(CFG_MEAS_NOISE, random_reg(CFG_MEAS_NOISE));
      write_reg(CFG_INIT_VAR, random_reg(CFG_INIT_VAR));
      quiet <= (done_items >= QUIET_FROM) || ($urandom_range(0, 3) == 0);
      it = random_cmd();
      it.cmd = CMD_SET;
      send_cmd(it, 1'b0, '0);
      done_items++;
      phase_len = $urandom_range(60, 160);
      repeat (phase_len) begin
        if (done_items < RAND_ITEMS) begin
          it = random_cmd();
          send_cmd(it, 1'b0, '0);
          if (it.cmd != CMD_UNUSED) done_items++;
          if (done_items >= QUIET_FROM) quiet <= 1'b1;
        end
      end
    end

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_cnt == 0 && estimate_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
